@@ sv/dtsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtsp_pkg
// Shared types and constants of the DNS TXT character-string parser.
// ----------------------------------------------------------------------------
package dtsp_pkg;

   localparam logic [7:0] MAX_STRING_LEN = 8'd255;
   localparam int         RES_SLOTS      = 3;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_SEMI      = 8'h3B;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_LENGTH = 2'd1,
      KIND_NOTICE = 2'd2,
      KIND_FATAL  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE          = 3'd0,
      ERR_BAD_ESCAPE    = 3'd1,
      ERR_TOO_LONG      = 3'd2,
      ERR_EMPTY         = 3'd3,
      ERR_MISSING_QUOTE = 3'd4,
      ERR_NO_DATA       = 3'd5
   } err_type;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_QUOTED   = 2'd1,
      MODE_UNQUOTED = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,
      ESC_SLASH = 2'd1,
      ESC_ONE   = 2'd2,
      ESC_TWO   = 2'd3
   } esc_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic [7:0] offset;
      err_type    error_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       can_load;
      logic [1:0] count;
   } q_status_type;

endpackage
`default_nettype wire

@@ sv/dtsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtsp_req_if / dtsp_rsp_if
// Valid/ready channels for input characters and parser results.
// ----------------------------------------------------------------------------
interface dtsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_data;

   modport source (output valid, output char_byte, output end_of_data, input ready);
   modport sink   (input valid, input char_byte, input end_of_data, output ready);
endinterface

interface dtsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic [7:0] offset;
   logic [2:0] error_code;
   logic       last;

   modport source (output valid, output kind, output value, output offset,
                   output error_code, output last, input ready);
   modport sink   (input valid, input kind, input value, input offset,
                   input error_code, input last, output ready);
endinterface
`default_nettype wire

@@ sv/dtsp_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtsp_parser
// Token state and one-character decode step, up to three results per beat.
// ----------------------------------------------------------------------------
module dtsp_parser
   import dtsp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic [7:0]                 char_byte,
   input  wire logic                       end_of_data,
   output      rsp_type [RES_SLOTS-1:0]    res,
   output      logic [1:0]                 res_cnt
);

   typedef struct packed {
      mode_type                mode;
      esc_type                 esc;
      logic [3:0]              d1;
      logic [3:0]              d2;
      logic [7:0]              len;
      logic [1:0]              cnt;
      rsp_type [RES_SLOTS-1:0] res;
   } step_type;

   mode_type   mode_ff, mode_in;
   esc_type    esc_ff, esc_in;
   logic [3:0] d1_ff, d1_in;
   logic [3:0] d2_ff, d2_in;
   logic [7:0] len_ff, len_in;
   step_type   nxt;

   function automatic logic is_dec(logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_delim(logic [7:0] c);
      return c == CHAR_NUL || c == CHAR_CR || c == CHAR_LF || c == CHAR_SEMI ||
             c == CHAR_LPAREN || c == CHAR_RPAREN || c == CHAR_SPACE || c == CHAR_TAB;
   endfunction

   function automatic step_type emit(step_type s, kind_type k, logic [7:0] v,
                                     logic [7:0] o, err_type e, logic l);
      step_type r;
      r = s;
      if (s.cnt != 2'd3) begin
         r.res[s.cnt] = '{kind: k, value: v, offset: o, error_code: e, last: l};
         r.cnt        = s.cnt + 2'd1;
      end
      return r;
   endfunction

   function automatic step_type finish(step_type s);
      step_type r;
      r      = s;
      r.mode = MODE_IDLE;
      r.esc  = ESC_NONE;
      r.d1   = 4'd0;
      r.d2   = 4'd0;
      r.len  = 8'd0;
      return r;
   endfunction

   function automatic step_type append_byte(step_type s, logic [7:0] b);
      step_type r;
      r = s;
      if (s.len >= MAX_STRING_LEN) begin
         r = emit(r, KIND_NOTICE, 8'd0, 8'd0, ERR_TOO_LONG, 1'b0);
      end else begin
         r.len = s.len + 8'd1;
         r     = emit(r, KIND_DATA, b, r.len, ERR_NONE, 1'b0);
      end
      return r;
   endfunction

   function automatic step_type end_unquoted(step_type s);
      step_type r;
      r = s;
      if (s.len == 8'd0) begin
         r = emit(r, KIND_FATAL, 8'd0, 8'd0, ERR_EMPTY, 1'b1);
      end else begin
         r = emit(r, KIND_LENGTH, s.len, 8'd0, ERR_NONE, 1'b1);
      end
      return finish(r);
   endfunction

   // character with no escape pending
   function automatic step_type take_plain(step_type s, logic [7:0] c, logic eod);
      step_type r;
      r = s;
      if (s.mode == MODE_QUOTED) begin
         if (eod) begin
            r = finish(emit(r, KIND_FATAL, 8'd0, 8'd0, ERR_MISSING_QUOTE, 1'b1));
         end else if (c == CHAR_QUOTE) begin
            r = finish(emit(r, KIND_LENGTH, s.len, 8'd0, ERR_NONE, 1'b1));
         end else if (c == CHAR_BACKSLASH) begin
            r.esc = ESC_SLASH;
         end else begin
            r = append_byte(r, c);
         end
      end else if (s.mode == MODE_UNQUOTED) begin
         if (eod || is_delim(c)) begin
            r = end_unquoted(r);
         end else if (c == CHAR_BACKSLASH) begin
            r.esc = ESC_SLASH;
         end else begin
            r = append_byte(r, c);
         end
      end else begin
         r = finish(r);
         if (eod) begin
            r = emit(r, KIND_FATAL, 8'd0, 8'd0, ERR_NO_DATA, 1'b1);
         end else if (c == CHAR_QUOTE) begin
            r.mode = MODE_QUOTED;
         end else if (is_delim(c)) begin
            r = emit(r, KIND_FATAL, 8'd0, 8'd0, ERR_EMPTY, 1'b1);
         end else if (c == CHAR_BACKSLASH) begin
            r.mode = MODE_UNQUOTED;
            r.esc  = ESC_SLASH;
         end else begin
            r.mode = MODE_UNQUOTED;
            r      = append_byte(r, c);
         end
      end
      return r;
   endfunction

   always_comb begin
      step_type    s;
      esc_type     phase;
      logic [10:0] v;
      logic        ok;
      logic [3:0]  d2_lit;

      s.mode = mode_ff;
      s.esc  = esc_ff;
      s.d1   = d1_ff;
      s.d2   = d2_ff;
      s.len  = len_ff;
      s.cnt  = 2'd0;
      s.res  = '0;

      phase  = (mode_ff == MODE_QUOTED || mode_ff == MODE_UNQUOTED) ? esc_ff : ESC_NONE;
      v      = 11'(d1_ff) * 11'd100 + 11'(d2_ff) * 11'd10 +
               (11'(char_byte) - 11'(CHAR_ZERO));
      ok     = !end_of_data && is_dec(char_byte) && (v <= 11'd255);
      d2_lit = (d2_ff >= 4'd10) ? d2_ff - 4'd10 : d2_ff;

      unique case (phase)
         ESC_SLASH: begin
            if (end_of_data) begin
               if (mode_ff == MODE_QUOTED) begin
                  s = finish(emit(s, KIND_FATAL, 8'd0, 8'd0, ERR_MISSING_QUOTE, 1'b1));
               end else begin
                  s = end_unquoted(s);
               end
            end else if (is_dec(char_byte)) begin
               s.d1  = 4'(char_byte - CHAR_ZERO);
               s.esc = ESC_ONE;
            end else begin
               s.esc = ESC_NONE;
               s     = append_byte(s, char_byte);
            end
         end
         ESC_ONE: begin
            if (!end_of_data && is_dec(char_byte)) begin
               s.d2  = 4'(char_byte - CHAR_ZERO);
               s.esc = ESC_TWO;
            end else begin
               s     = emit(s, KIND_NOTICE, 8'd0, 8'd0, ERR_BAD_ESCAPE, 1'b0);
               s.esc = ESC_NONE;
               s     = take_plain(s, char_byte, end_of_data);
            end
         end
         ESC_TWO: begin
            s.esc = ESC_NONE;
            if (ok) begin
               s = append_byte(s, v[7:0]);
            end else begin
               // bad \DDD: drop first digit, replay second digit and this char
               s = emit(s, KIND_NOTICE, 8'd0, 8'd0, ERR_BAD_ESCAPE, 1'b0);
               s = append_byte(s, CHAR_ZERO + 8'(d2_lit));
               s = take_plain(s, char_byte, end_of_data);
            end
         end
         default: begin
            s.esc = ESC_NONE;
            s     = take_plain(s, char_byte, end_of_data);
         end
      endcase
      nxt = s;
   end

   assign mode_in = nxt.mode;
   assign esc_in  = nxt.esc;
   assign d1_in   = nxt.d1;
   assign d2_in   = nxt.d2;
   assign len_in  = nxt.len;
   assign res     = nxt.res;
   assign res_cnt = nxt.cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         esc_ff  <= ESC_NONE;
         d1_ff   <= 4'd0;
         d2_ff   <= 4'd0;
         len_ff  <= 8'd0;
      end else if (advance) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;
         len_ff  <= len_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/dtsp_result_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtsp_result_queue
// Three-slot result buffer, drained one beat per cycle from slot zero while the sink is ready.
// ----------------------------------------------------------------------------
module dtsp_result_queue
   import dtsp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire rsp_type [RES_SLOTS-1:0] res,
   input  wire logic [1:0]              res_cnt,
   output      q_status_type            status,
   dtsp_rsp_if.source                   rsp
);

   rsp_type [RES_SLOTS-1:0] slot_ff;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    pop;

   assign pop = rsp.valid && rsp.ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = res_cnt;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= res;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   // room for a full item once the last held beat leaves
   assign status.can_load = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp.ready);
   assign status.count    = cnt_ff;

   assign rsp.valid      = cnt_ff != 2'd0;
   assign rsp.kind       = slot_ff[0].kind;
   assign rsp.value      = slot_ff[0].value;
   assign rsp.offset     = slot_ff[0].offset;
   assign rsp.error_code = slot_ff[0].error_code;
   assign rsp.last       = slot_ff[0].last;

endmodule
`default_nettype wire

@@ sv/dns_txt_string_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dns_txt_string_parser
// Zone-file character-string parser, one input character per beat.
// ----------------------------------------------------------------------------
// Takes one character per cycle unless the result buffer holds it off, and
// emits decoded bytes with their wire offsets, the string length at the
// token end (it belongs at offset 0), and error notices. Plain text streams
// at one character per clock while results are taken; a request passes the
// input register and then the result buffer on its way to the first result.
// A character that yields k results (at most three: a bad \DDD replay)
// fills the three-slot result buffer, and the request side waits until at
// most one result beat is left and that beat is taken in the same cycle;
// the buffer drains one beat per ready cycle and sets the sustained rate.
// ----------------------------------------------------------------------------
module dns_txt_string_parser
   import dtsp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   dtsp_req_if.sink   req_bus,
   dtsp_rsp_if.source rsp_bus
);

   // input register
   logic       s1_valid_ff;
   logic [7:0] s1_char_ff;
   logic       s1_eod_ff;

   logic                    advance;
   q_status_type            q_status;
   rsp_type [RES_SLOTS-1:0] step_res;
   logic [1:0]              step_cnt;

   // decode the held character once the buffer can take all its results
   assign advance       = s1_valid_ff && q_status.can_load;
   assign req_bus.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_char_ff <= req_bus.char_byte;
         s1_eod_ff  <= req_bus.end_of_data;
      end
   end

   dtsp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .char_byte   (s1_char_ff),
      .end_of_data (s1_eod_ff),
      .res         (step_res),
      .res_cnt     (step_cnt)
   );

   dtsp_result_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .load    (advance),
      .res     (step_res),
      .res_cnt (step_cnt),
      .status  (q_status),
      .rsp     (rsp_bus)
   );

`ifndef SYNTHESIS
   // a blocked character stays in the input register untouched
   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !q_status.can_load) |=> (s1_valid_ff && $stable(s1_char_ff)
      && $stable(s1_eod_ff)))
      else $error("blocked input beat changed");

   // new beat only lands in an empty or draining input register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> (!s1_valid_ff || advance))
      else $error("input register overwritten");

   // last buffered beat taken with nothing new leaves the output empty
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && q_status.count == 2'd1 && !advance)
      |=> !rsp_bus.valid)
      else $error("result appeared from nowhere");

   // results are only loaded into a buffer that will be empty
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      (advance && q_status.count != 2'd0) |-> (q_status.count == 2'd1 && rsp_bus.ready))
      else $error("result buffer overrun");
`endif

endmodule
`default_nettype wire

@@ dv/tb_dns_txt_string_parser.sv @@
// ----------------------------------------------------------------------------
// tb_dns_txt_string_parser
// Self-checking bench for the zone-file character-string parser: a directed
// pass over the corner cases, then random well-formed and broken tokens with
// random idle on both channels. A class-based scoreboard predicts every
// result beat and checks the response stream field by field, in order.
// ----------------------------------------------------------------------------
module tb_dns_txt_string_parser
   import dtsp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_CHARS = 120;   // random chars after the directed pass
   localparam int DRAIN_TAIL   = 8;     // cycles past the last result
   localparam int STALL_LIMIT  = 2000;  // cycles with no beat before giving up

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the parser state and keeps the queue of result beats
   // the block still owes us.
   // -------------------------------------------------------------------------
   class txt_decoder_sb;
      mode_type   mode;
      esc_type    esc;
      logic [3:0] digit_hi;
      logic [3:0] digit_mid;
      logic [7:0] kept_len;
      rsp_type    owed_q[$];
      int         errors;
      int         step_beats;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         mode      = MODE_IDLE;
         esc       = ESC_NONE;
         digit_hi  = '0;
         digit_mid = '0;
         kept_len  = '0;
      endfunction

      function bit is_num_char(logic [7:0] c);
         return c >= CHAR_ZERO && c <= CHAR_NINE;
      endfunction

      function bit is_delim(logic [7:0] c);
         return c == CHAR_NUL || c == CHAR_CR || c == CHAR_LF || c == CHAR_SEMI ||
                c == CHAR_LPAREN || c == CHAR_RPAREN || c == CHAR_SPACE ||
                c == CHAR_TAB;
      endfunction

      function void owe(kind_type k, logic [7:0] v, logic [7:0] off, err_type e,
                        logic l);
         rsp_type r;
         if (step_beats >= RES_SLOTS) return;
         r.kind       = k;
         r.value      = v;
         r.offset     = off;
         r.error_code = e;
         r.last       = l;
         owed_q.push_back(r);
         step_beats++;
      endfunction

      function void keep_byte(logic [7:0] b);
         if (kept_len >= MAX_STRING_LEN) begin
            owe(KIND_NOTICE, 8'd0, 8'd0, ERR_TOO_LONG, 1'b0);
         end else begin
            kept_len = kept_len + 8'd1;
            owe(KIND_DATA, b, kept_len, ERR_NONE, 1'b0);
         end
      endfunction

      function void close_bare();
         if (kept_len == 8'd0) owe(KIND_FATAL, 8'd0, 8'd0, ERR_EMPTY, 1'b1);
         else owe(KIND_LENGTH, kept_len, 8'd0, ERR_NONE, 1'b1);
         restart();
      endfunction

      // character with no escape pending
      function void plain_char(logic [7:0] c, bit eod);
         if (mode == MODE_QUOTED) begin
            if (eod) begin
               owe(KIND_FATAL, 8'd0, 8'd0, ERR_MISSING_QUOTE, 1'b1);
               restart();
            end else if (c == CHAR_QUOTE) begin
               owe(KIND_LENGTH, kept_len, 8'd0, ERR_NONE, 1'b1);
               restart();
            end else if (c == CHAR_BACKSLASH) begin
               esc = ESC_SLASH;
            end else begin
               keep_byte(c);
            end
         end else if (mode == MODE_UNQUOTED) begin
            if (eod || is_delim(c)) close_bare();
            else if (c == CHAR_BACKSLASH) esc = ESC_SLASH;
            else keep_byte(c);
         end else begin
            restart();
            if (eod) begin
               owe(KIND_FATAL, 8'd0, 8'd0, ERR_NO_DATA, 1'b1);
            end else if (c == CHAR_QUOTE) begin
               mode = MODE_QUOTED;
            end else if (is_delim(c)) begin
               owe(KIND_FATAL, 8'd0, 8'd0, ERR_EMPTY, 1'b1);
            end else if (c == CHAR_BACKSLASH) begin
               mode = MODE_UNQUOTED;
               esc  = ESC_SLASH;
            end else begin
               mode = MODE_UNQUOTED;
               keep_byte(c);
            end
         end
      endfunction

      // one accepted input beat: queue everything it must produce
      function void note_char(logic [7:0] c, bit eod);
         esc_type phase;
         int      v;
         bit      ok;
         step_beats = 0;
         phase      = esc;
         if (mode != MODE_QUOTED && mode != MODE_UNQUOTED) phase = ESC_NONE;
         case (phase)
            ESC_SLASH: begin
               if (eod) begin
                  if (mode == MODE_QUOTED) begin
                     owe(KIND_FATAL, 8'd0, 8'd0, ERR_MISSING_QUOTE, 1'b1);
                     restart();
                  end else begin
                     close_bare();
                  end
               end else if (is_num_char(c)) begin
                  digit_hi = 4'(c - CHAR_ZERO);
                  esc      = ESC_ONE;
               end else begin
                  esc = ESC_NONE;
                  keep_byte(c);
               end
            end
            ESC_ONE: begin
               if (!eod && is_num_char(c)) begin
                  digit_mid = 4'(c - CHAR_ZERO);
                  esc       = ESC_TWO;
               end else begin
                  owe(KIND_NOTICE, 8'd0, 8'd0, ERR_BAD_ESCAPE, 1'b0);
                  esc = ESC_NONE;
                  plain_char(c, eod);
               end
            end
            ESC_TWO: begin
               v  = 0;
               ok = !eod && is_num_char(c);
               if (ok) begin
                  v  = int'(digit_hi) * 100 + int'(digit_mid) * 10 + int'(c - CHAR_ZERO);
                  ok = v <= 255;
               end
               esc = ESC_NONE;
               if (ok) begin
                  keep_byte(8'(v));
               end else begin
                  // first digit dropped, second replayed as a literal
                  owe(KIND_NOTICE, 8'd0, 8'd0, ERR_BAD_ESCAPE, 1'b0);
                  keep_byte(CHAR_ZERO + 8'(digit_mid % 10));
                  plain_char(c, eod);
               end
            end
            default: begin
               esc = ESC_NONE;
               plain_char(c, eod);
            end
         endcase
      endfunction

      function void field_check(string name, int want, int seen);
         if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result beat, actual kind %0d value %0d", $time,
                     got.kind, got.value);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         field_check("kind", want.kind, got.kind);
         field_check("value", want.value, got.value);
         field_check("offset", want.offset, got.offset);
         field_check("error_code", want.error_code, got.error_code);
         field_check("last", want.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;          // when set, neither side inserts idle cycles
   int   chars_sent;
   int   quiet_cycles;

   txt_decoder_sb sb;

   dtsp_req_if req_bus();
   dtsp_rsp_if rsp_bus();

   dns_txt_string_parser DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // All drive happens at the falling edge, all sampling at the rising edge,
   // so DUT registers and bench never race inside one time step.

   // Result side: random backpressure, redrawn after every accepted beat.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // Result monitor: every accepted beat goes to the scoreboard.
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kind       = kind_type'(rsp_bus.kind);
         got.value      = rsp_bus.value;
         got.offset     = rsp_bus.offset;
         got.error_code = err_type'(rsp_bus.error_code);
         got.last       = rsp_bus.last;
         sb.check_result(got);
      end
   end

   // Watchdog: a hung handshake on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // One input beat. Entered just after a falling edge, returns at one.
   // valid only drops when a gap is drawn, so back-to-back beats keep it high.
   task automatic send_char(logic [7:0] c, bit eod);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.char_byte   = c;
      req_bus.end_of_data = eod;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_char(c, eod);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_str(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   // Sender holds off until the block has delivered everything it owes.
   task automatic drain();
      req_bus.valid = 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_delim();
      case ($urandom_range(0, 7))
         0:       return CHAR_NUL;
         1:       return CHAR_CR;
         2:       return CHAR_LF;
         3:       return CHAR_SEMI;
         4:       return CHAR_LPAREN;
         5:       return CHAR_RPAREN;
         6:       return CHAR_SPACE;
         default: return CHAR_TAB;
      endcase
   endfunction

   // Any byte that reads as an ordinary content byte in this token form;
   // no_digit also keeps it from extending a decimal escape.
   function automatic logic [7:0] pick_plain(bit quoted, bit no_digit);
      logic [7:0] c;
      bit         bad;
      do begin
         c   = 8'($urandom_range(0, 255));
         bad = c == CHAR_QUOTE || c == CHAR_BACKSLASH ||
               (!quoted && sb.is_delim(c)) ||
               (no_digit && c >= CHAR_ZERO && c <= CHAR_NINE);
      end while (bad);
      return c;
   endfunction

   function automatic logic [7:0] pick_digit(int hi);
      return CHAR_ZERO + 8'($urandom_range(0, hi));
   endfunction

   // One piece of token content: plain byte, escaped byte, \DDD or a broken \DDD.
   task automatic send_unit(bit quoted);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         send_char(pick_plain(quoted, 1'b0), 1'b0);
      end else if (r < 72) begin
         send_char(CHAR_BACKSLASH, 1'b0);
         send_char(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 90) begin
         // mostly legal values, some above 255
         send_char(CHAR_BACKSLASH, 1'b0);
         send_char(pick_digit($urandom_range(0, 3) == 0 ? 9 : 2), 1'b0);
         send_char(pick_digit(9), 1'b0);
         send_char(pick_digit(9), 1'b0);
      end else begin
         send_char(CHAR_BACKSLASH, 1'b0);
         send_char(pick_digit(9), 1'b0);
         if ($urandom_range(0, 1) == 1) send_char(pick_digit(9), 1'b0);
         send_char(pick_plain(quoted, 1'b1), 1'b0);
      end
   endtask

   // Mostly well-formed tokens; some end early at end of data, some are noise.
   task automatic send_token(int units);
      int form;
      form = $urandom_range(0, 99);
      if (form < 45) begin
         send_char(CHAR_QUOTE, 1'b0);
         repeat (units) send_unit(1'b1);
         if ($urandom_range(0, 99) < 85) send_char(CHAR_QUOTE, 1'b0);
         else send_char(8'($urandom_range(0, 255)), 1'b1);
      end else if (form < 85) begin
         repeat (units) send_unit(1'b0);
         if ($urandom_range(0, 99) < 80) send_char(pick_delim(), 1'b0);
         else send_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         repeat ($urandom_range(1, 6))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      bit paused;
      int random_goal;
      sb                  = new();
      steady              = 1'b0;
      paused              = 1'b0;
      chars_sent          = 0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.char_byte   = 8'h00;
      req_bus.end_of_data = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed ----------------------------------------------------------
      send_char(8'hFF, 1'b1);               // end of data while idle
      send_char(CHAR_SPACE, 1'b0);          // delimiter while idle
      send_str("a\"");                      // unquoted, quote is a plain byte
      send_char(8'hFF, 1'b0);               // top byte value
      send_char(CHAR_SEMI, 1'b0);           // delimiter ends the token
      // quoted: \255 at the limit, \256 replayed, \1x broken after one digit,
      // then a backslash right at the end of data
      send_str("\"\\255\\256\\1x\\");
      send_char(8'h00, 1'b1);
      // unquoted starting with an escape, trailing backslash at end of data
      send_str("\\ \\");
      send_char(8'h5A, 1'b1);

      // ---- random ------------------------------------------------------------
      random_goal = chars_sent + RANDOM_CHARS;
      while (chars_sent < random_goal) begin
         steady = $urandom_range(0, 4) == 0;
         send_token($urandom_range(0, 19) == 0 ? $urandom_range(9, 20)
                                                : $urandom_range(0, 8));
         if (!paused && chars_sent > random_goal - RANDOM_CHARS / 2) begin
            drain();
            paused = 1'b1;
         end
      end

      steady = 1'b0;
      drain();

      // ---- wrap up -----------------------------------------------------------
      if (sb.errors == 0 && sb.owed_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (sb.owed_q.size() != 0)
            $display("%0t: %0d expected beats never arrived", $time, sb.owed_q.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/dtsp_pkg.sv
sv/dtsp_if.sv
sv/dtsp_parser.sv
sv/dtsp_result_queue.sv
sv/dns_txt_string_parser.sv
dv/tb_dns_txt_string_parser.sv
